[src/ehrc_pkg.sv]
`default_nettype none
package ehrc_pkg;

   localparam int unsigned BANK_COUNT_DEF  = 4;
   localparam int unsigned TOF_BINS_DEF    = 1024;
   localparam int unsigned ENERGY_BINS_DEF = 256;
   localparam int unsigned COUNT_WIDTH_DEF = 24;

   localparam int unsigned TPS_WIDTH  = 32;
   localparam int unsigned BANK_WIDTH = 8;
   localparam int unsigned CHAN_WIDTH = 16;
   localparam int unsigned TIME_WIDTH = 32;
   localparam int unsigned RAW_WIDTH  = 24;
   localparam int unsigned RATE_WIDTH = 48;
   localparam int unsigned FRAC_BITS  = 8;

   localparam int unsigned REQ_DATA_WIDTH = 72;
   localparam int unsigned RSP_DATA_WIDTH = 80;

   localparam logic [31:0] TPS_RESET = 32'd1000;

   // register indexes
   localparam logic CSR_TICKS_PER_SECOND      = 1'b0;
   localparam logic CSR_FIRST_NORMALIZED_BANK = 1'b1;

   // request kinds
   localparam logic OP_EVENT = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_BANK = 2'd1;
   localparam logic [1:0] STATUS_BAD_CHAN = 2'd2;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic exec;
      logic mul;
      logic div_step;
      logic load_rsp;
   } ehrc_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic normalize;
      logic div_last;
      logic rsp_free;
   } ehrc_sts_type;

endpackage
`default_nettype wire

[src/event_histogram_rate_cube.sv]
// Event, bad-index and plain reads go from accept through the READ, EXEC and DONE states
// to a registered rsp_tvalid; normalized reads add MUL and then DIV, where the restoring
// divider makes one quotient bit per cycle of a COUNT_WIDTH+40 bit quotient; the bin memory
// and the divider are not overlapped. No new request is taken until the response is loaded.
// Reset is synchronous: afterwards a clearing pass zeroes all BANK_COUNT*TOF_BINS*ENERGY_BINS
// bins (1048576 by default), one bin per cycle, with req_tready held low.
`default_nettype none
module event_histogram_rate_cube
   import ehrc_pkg::*;
#(
   parameter int unsigned BANK_COUNT  = BANK_COUNT_DEF,
   parameter int unsigned TOF_BINS    = TOF_BINS_DEF,
   parameter int unsigned ENERGY_BINS = ENERGY_BINS_DEF,
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // configuration writes
   input  wire logic                      csr_we,
   input  wire logic                      csr_addr,
   input  wire logic [TPS_WIDTH-1:0]      csr_wdata,
   // request channel
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   // bank_index[7:0], tof_channel[23:8], energy_channel[39:24], event_time[71:40]
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // opcode[0]
   input  wire logic [0:0]                req_tuser,
   // response channel
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   // status[1:0], raw_count[25:2], rate[73:26], normalized[74], zero fill above
   output      logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);
   ehrc_cmd_type cmd;
   ehrc_sts_type sts;

   // sequence clearing, request accept, memory access and the divide loop
   ehrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // hold registers, bin memory, saturating increment and rate divider
   ehrc_dp #(
      .BANK_COUNT  (BANK_COUNT),
      .TOF_BINS    (TOF_BINS),
      .ENERGY_BINS (ENERGY_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );
endmodule
`default_nettype wire

[src/ehrc_ram.sv]
`default_nettype none
module ehrc_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [AW-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic                  rd_en,
   input  wire logic [AW-1:0]         rd_addr,
   output      logic [WIDTH-1:0]      rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

[src/ehrc_ctrl.sv]
`default_nettype none
module ehrc_ctrl
   import ehrc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output      logic         req_tready,
   input  wire ehrc_sts_type sts,
   output      ehrc_cmd_type cmd
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_EXEC  = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DIV   = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.normalize ? ST_MUL : ST_DONE;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

[src/ehrc_dp.sv]
`default_nettype none
module ehrc_dp
   import ehrc_pkg::*;
#(
   parameter int unsigned BANK_COUNT  = BANK_COUNT_DEF,
   parameter int unsigned TOF_BINS    = TOF_BINS_DEF,
   parameter int unsigned ENERGY_BINS = ENERGY_BINS_DEF,
   parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_we,
   input  wire logic                      csr_addr,
   input  wire logic [TPS_WIDTH-1:0]      csr_wdata,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,
   input  wire logic [0:0]                req_tuser,
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   output      logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  wire ehrc_cmd_type              cmd,
   output      ehrc_sts_type              sts
);
   localparam int unsigned DEPTH = BANK_COUNT * TOF_BINS * ENERGY_BINS;
   localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned DW    = COUNT_WIDTH + TPS_WIDTH + FRAC_BITS;
   localparam int unsigned PW    = COUNT_WIDTH + TPS_WIDTH;
   localparam int unsigned DCW   = $clog2(DW);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   logic [TPS_WIDTH-1:0]  tps_ff;
   logic [BANK_WIDTH-1:0] fnb_ff;
   logic [TIME_WIDTH-1:0] first_ff, last_ff;
   logic                  seen_ff;

   logic                  op_ff;
   logic [BANK_WIDTH-1:0] bank_ff;
   logic [1:0]            status_ff;
   logic [AW-1:0]         addr_ff;
   logic [AW-1:0]         clr_ff;

   logic [COUNT_WIDTH-1:0] cnt_ff;
   logic [RAW_WIDTH-1:0]   res_count_ff;
   logic [RATE_WIDTH-1:0]  res_rate_ff;
   logic                   res_norm_ff;
   logic [1:0]             res_status_ff;

   logic [DW-1:0]         quo_ff;
   logic [TIME_WIDTH-1:0] rem_ff;
   logic [DCW-1:0]        div_cnt_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff;

   logic [BANK_WIDTH-1:0] req_bank;
   logic [CHAN_WIDTH-1:0] req_tof, req_energy;
   logic [TIME_WIDTH-1:0] req_time;
   logic [1:0]            req_status;
   logic [AW-1:0]         req_addr;

   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [COUNT_WIDTH-1:0] mem_wdata, mem_rdata, cnt_inc;
   logic                   norm_cond;
   logic [TIME_WIDTH-1:0]  interval;
   logic [TIME_WIDTH:0]    rem_sh, rem_diff;
   logic                   q_bit;
   logic [RATE_WIDTH-1:0]  norm_rate;

   assign req_bank   = req_tdata[7:0];
   assign req_tof    = req_tdata[23:8];
   assign req_energy = req_tdata[39:24];
   assign req_time   = req_tdata[71:40];

   always_comb begin
      priority if (32'(req_bank) >= BANK_COUNT) begin
         req_status = STATUS_BAD_BANK;
      end else if (32'(req_tof) >= TOF_BINS || 32'(req_energy) >= ENERGY_BINS) begin
         req_status = STATUS_BAD_CHAN;
      end else begin
         req_status = STATUS_OK;
      end
   end

   assign req_addr = (AW'(req_bank) * AW'(TOF_BINS) + AW'(req_tof)) * AW'(ENERGY_BINS)
                     + AW'(req_energy);

   // config registers and event times
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff   <= TPS_RESET;
         fnb_ff   <= '0;
         first_ff <= '0;
         last_ff  <= '0;
         seen_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_TICKS_PER_SECOND:      tps_ff <= csr_wdata;
               CSR_FIRST_NORMALIZED_BANK: fnb_ff <= csr_wdata[BANK_WIDTH-1:0];
               default: ;
            endcase
         end
         if (cmd.accept && req_tuser[0] == OP_EVENT) begin
            if (!seen_ff) first_ff <= req_time;
            last_ff <= req_time;
            seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_tuser[0];
         bank_ff   <= req_bank;
         status_ff <= req_status;
         addr_ff   <= req_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   assign cnt_inc   = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + COUNT_WIDTH'(1);
   assign mem_we    = cmd.clear_wr ||
                      (cmd.exec && op_ff == OP_EVENT && status_ff == STATUS_OK);
   assign mem_waddr = cmd.clear_wr ? clr_ff : addr_ff;
   assign mem_wdata = cmd.clear_wr ? '0 : cnt_inc;

   ehrc_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (DEPTH)
   ) u_bins (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (cmd.accept),
      .rd_addr (req_addr),
      .rd_data (mem_rdata)
   );

   assign interval  = last_ff - first_ff;
   assign norm_cond = op_ff == OP_READ && status_ff == STATUS_OK && bank_ff >= fnb_ff &&
                      seen_ff && last_ff > first_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         cnt_ff        <= mem_rdata;
         res_status_ff <= status_ff;
         res_norm_ff   <= norm_cond;
         if (status_ff != STATUS_OK) begin
            res_count_ff <= '0;
            res_rate_ff  <= '0;
         end else if (op_ff == OP_EVENT) begin
            res_count_ff <= RAW_WIDTH'(cnt_inc);
            res_rate_ff  <= '0;
         end else begin
            res_count_ff <= RAW_WIDTH'(mem_rdata);
            res_rate_ff  <= RATE_WIDTH'({mem_rdata, {FRAC_BITS{1'b0}}});
         end
      end
   end

   // restoring divider, one quotient bit a cycle
   assign rem_sh   = {rem_ff, quo_ff[DW-1]};
   assign rem_diff = rem_sh - {1'b0, interval};
   assign q_bit    = !rem_diff[TIME_WIDTH];

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         quo_ff     <= {PW'(cnt_ff) * PW'(tps_ff), {FRAC_BITS{1'b0}}};
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff     <= {quo_ff[DW-2:0], q_bit};
         rem_ff     <= q_bit ? rem_diff[TIME_WIDTH-1:0] : rem_sh[TIME_WIDTH-1:0];
         div_cnt_ff <= div_cnt_ff + DCW'(1);
      end
   end

   assign norm_rate = ((quo_ff >> RATE_WIDTH) != '0) ? '1 : quo_ff[RATE_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {5'd0, res_norm_ff, res_norm_ff ? norm_rate : res_rate_ff,
                         res_count_ff, res_status_ff};
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = rsp_data_ff;
   assign sts.clear_last = (32'(clr_ff) == DEPTH - 1);
   assign sts.normalize  = norm_cond;
   assign sts.div_last   = (32'(div_cnt_ff) == DW - 1);
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;
endmodule
`default_nettype wire
